// ----- rtl/core/rwt_pkg.sv -----
`timescale 1ns / 1ps

package rwt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd2;

    localparam logic [47:0] WINDOW_RESET = 48'd90000000000;
    localparam logic [47:0] CHECK_RESET  = 48'd3000000000;
    localparam logic [15:0] FACTOR_RESET = 16'd384;

    // 1.0 in Q16.8
    localparam logic [23:0] Q8_ONE = 24'd256;

    localparam logic [1:0] REQ_APPLY = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_EXIT  = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [23:0] baseline;
        logic [63:0] window_end;
        logic [63:0] last_check;
        logic        live;
        logic        done_bad;
    } entry_t;

    // found sits in the lowest bit
    typedef struct packed {
        logic dropped_full;
        logic window_expired;
        logic revert_now;
        logic is_reverted;
        logic is_active;
        logic found;
    } result_t;

endpackage

// ----- rtl/core/rwt_table.sv -----
`timescale 1ns / 1ps

module rwt_table
    import rwt_pkg::*;
(
    input  logic             aclk,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/regression_watch_table.sv -----
`timescale 1ns / 1ps

// regression watch table
// input stream: s_tuser carries the request kind (apply, tick, exit), s_tdata
// carries id, variance and timestamp. one result transfer comes out on m_tdata
// per input transfer, in order, holding six status bits.
// the block works on one item at a time: s_tready is high only while idle.
// the id search reads the table one entry at a time, in two states: S_LOOK
// presents the address, S_CMP compares the registered data. the search stops
// at a hit or after all entries (the entry count, at most 16); ticks that reach
// a check then pass through S_CHECK, exits through S_EXIT for the move of the
// last entry, before the result is registered in S_DONE.
// a finished result waits in the output register; if the receiver stalls and a
// second item finishes, that item holds until the first result is taken.
// reset (aresetn low, synchronous) empties the table and restores the
// configuration defaults; no clearing pass is needed.
// configuration writes (cfg_wr_en, cfg_addr, cfg_wr_data) apply at once and
// are to be made only while the block is idle.

module regression_watch_table
    import rwt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [119:0]          s_tdata,   // pid[31:0], variance[55:32], now[119:56]
    input  logic [1:0]            s_tuser,   // req_type[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // found, is_active, is_reverted, revert_now,
                                             // window_expired, dropped_full, zero pad
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_CMP, S_DECIDE, S_CHECK, S_EXIT, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        type_reg, type_next;
    logic [31:0]       pid_reg, pid_next;
    logic [23:0]       var_reg, var_next;
    logic [63:0]       now_reg, now_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  hit_reg, hit_next;
    logic              found_reg, found_next;
    entry_t            ent_reg, ent_next;
    logic [63:0]       diff_reg, diff_next;
    logic [39:0]       thr_reg, thr_next;
    result_t           res_reg, res_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic [47:0]       window_reg, check_reg;
    logic [15:0]       factor_reg;

    logic [IDX_W-1:0]  rd_addr, wr_addr;
    entry_t            rd_data, wr_data;
    logic              wr_en;
    logic [39:0]       prod;
    logic [CNT_W-1:0]  last_idx;

    rwt_table u_table (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign prod     = ent_reg.baseline * factor_reg;
    assign last_idx = count_reg - CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        type_next     = type_reg;
        pid_next      = pid_reg;
        var_next      = var_reg;
        now_next      = now_reg;
        scan_next     = scan_reg;
        count_next    = count_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        ent_next      = ent_reg;
        diff_next     = diff_reg;
        thr_next      = thr_reg;
        res_next      = res_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rd_addr       = scan_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = hit_reg;
        wr_data       = ent_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    type_next  = s_tuser;
                    pid_next   = s_tdata[31:0];
                    var_next   = s_tdata[55:32];
                    now_next   = s_tdata[119:56];
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                if (scan_reg == count_reg) begin
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (rd_data.id == pid_reg) begin
                    found_next = 1'b1;
                    hit_next   = scan_reg[IDX_W-1:0];
                    ent_next   = rd_data;
                    state_next = S_DECIDE;
                end else begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = S_LOOK;
                end
            end
            S_DECIDE: begin
                res_next       = '0;
                res_next.found = found_reg;
                state_next     = S_DONE;
                case (type_reg)
                    REQ_APPLY: begin
                        if (!found_reg && count_reg == CNT_W'(MAX_ENTRIES)) begin
                            res_next.dropped_full = 1'b1;
                        end else begin
                            wr_en               = 1'b1;
                            wr_addr             = found_reg ? hit_reg : count_reg[IDX_W-1:0];
                            wr_data.id          = pid_reg;
                            wr_data.baseline    = (var_reg == '0) ? Q8_ONE : var_reg;
                            wr_data.window_end  = now_reg + {16'd0, window_reg};
                            wr_data.last_check  = now_reg;
                            wr_data.live        = 1'b1;
                            wr_data.done_bad    = 1'b0;
                            res_next.is_active  = 1'b1;
                            if (!found_reg) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    REQ_TICK: begin
                        res_next.is_active   = found_reg && ent_reg.live;
                        res_next.is_reverted = found_reg && ent_reg.done_bad;
                        if (found_reg && ent_reg.live) begin
                            thr_next  = prod;
                            diff_next = now_reg - ent_reg.last_check;
                            if (now_reg >= ent_reg.window_end) begin
                                wr_en                   = 1'b1;
                                wr_data.live            = 1'b0;
                                res_next.is_active      = 1'b0;
                                res_next.window_expired = 1'b1;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                    end
                    REQ_EXIT: begin
                        if (found_reg) begin
                            // move the last entry into the freed slot
                            count_next = last_idx;
                            rd_addr    = last_idx[IDX_W-1:0];
                            state_next = S_EXIT;
                        end
                    end
                    default: begin
                        res_next.is_active   = found_reg && ent_reg.live;
                        res_next.is_reverted = found_reg && ent_reg.done_bad;
                    end
                endcase
            end
            S_CHECK: begin
                if (diff_reg >= {16'd0, check_reg}) begin
                    wr_en              = 1'b1;
                    wr_data.last_check = now_reg;
                    if ({8'd0, var_reg, 8'd0} > thr_reg) begin
                        wr_data.live         = 1'b0;
                        wr_data.done_bad     = 1'b1;
                        res_next.is_active   = 1'b0;
                        res_next.is_reverted = 1'b1;
                        res_next.revert_now  = 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_EXIT: begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, res_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            window_reg   <= WINDOW_RESET;
            check_reg    <= CHECK_RESET;
            factor_reg   <= FACTOR_RESET;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_WINDOW: window_reg <= cfg_wr_data;
                    REG_CHECK:  check_reg  <= cfg_wr_data;
                    REG_FACTOR: factor_reg <= cfg_wr_data[15:0];
                    default: ;
                endcase
            end
        end
        type_reg    <= type_next;
        pid_reg     <= pid_next;
        var_reg     <= var_next;
        now_reg     <= now_next;
        scan_reg    <= scan_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        ent_reg     <= ent_next;
        diff_reg    <= diff_next;
        thr_reg     <= thr_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/rwt_checker.sv -----
`timescale 1ns / 1ps

module rwt_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [7:0]            m_tdata
);

    // one item at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous item in flight");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> !m_tdata[0] && !m_tdata[1] && !m_tdata[2])
        else $error("dropped apply reports an entry");

    a_revert_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[0] && !m_tdata[1] && m_tdata[2] && !m_tdata[4])
        else $error("revert result inconsistent");

    a_expire_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[0] && !m_tdata[1] && !m_tdata[5])
        else $error("expire result inconsistent");

endmodule

bind regression_watch_table rwt_checker u_rwt_checker (.*);
